// File: src/csms_pkg.sv
// ----------------------------------------------------------------------------
// csms_pkg
// Shared types, constants and helpers of the checked slot mailbox store.
// ----------------------------------------------------------------------------
package csms_pkg;

   // table geometry
   localparam int SLOT_COUNT = 8;
   localparam int SLOT_BYTES = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int POS_W      = $clog2(SLOT_BYTES + 1);
   localparam int MEM_DEPTH  = SLOT_COUNT * SLOT_BYTES;
   localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SIZE_W     = 7;

   localparam logic [7:0] SLOT_COUNT_B = 8'(SLOT_COUNT);
   localparam logic [7:0] SLOT_BYTES_B = 8'(SLOT_BYTES);
   localparam logic [7:0] TAG_EMPTY    = 8'hFF;

   // request commands
   typedef enum logic [1:0] {
      CMD_WRITE_BEGIN = 2'd0,
      CMD_WRITE_DATA  = 2'd1,
      CMD_READ        = 2'd2
   } cmd_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BOUND     = 3'd1,
      STAT_TOO_LARGE = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_BUF_SMALL = 3'd4,
      STAT_INVALID   = 3'd5
   } status_type;

   // classified operation kinds
   typedef enum logic [1:0] {
      OP_ERROR = 2'd0,
      OP_BEGIN = 2'd1,
      OP_DATA  = 2'd2,
      OP_READ  = 2'd3
   } op_kind_type;

   // one classified item handed from front to back
   typedef struct packed {
      op_kind_type            kind;
      status_type             status;
      logic [IDX_W-1:0]       slot;
      logic [7:0]             arg;
   } op_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SUM   = 2'd1,
      S_CHECK = 2'd2,
      S_EMIT  = 2'd3
   } state_type;

   // byte sum folded twice and inverted
   function automatic logic [15:0] fold_invert(input logic [15:0] s);
      logic [8:0] v;
      begin
         v = 9'(s[15:8]) + 9'(s[7:0]);
         v = v + 9'(v[8]);
         fold_invert = ~{7'd0, v};
      end
   endfunction

   // flat byte address of a slot position
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] slot,
                                                  input logic [POS_W-1:0] pos);
      begin
         mem_addr = ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos);
      end
   endfunction

endpackage

// File: src/csms_front.sv
// ----------------------------------------------------------------------------
// csms_front
// Accepts request items, range-checks them and turns them into operations.
// ----------------------------------------------------------------------------
module csms_front
   import csms_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [31:0] req_tdata,   // slot, data_size, data_byte, buffer_length
   input  logic        q_full,
   output logic        q_push,
   output op_type      q_op
);

   logic [7:0] slot;
   logic [7:0] data_size;
   logic [7:0] data_byte;
   logic [7:0] buffer_length;

   assign slot          = req_tdata[7:0];
   assign data_size     = req_tdata[15:8];
   assign data_byte     = req_tdata[23:16];
   assign buffer_length = req_tdata[31:24];

   // take an item whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // classify the command
   always_comb begin
      q_op.kind   = OP_ERROR;
      q_op.status = STAT_INVALID;
      q_op.slot   = slot[IDX_W-1:0];
      q_op.arg    = 8'd0;
      unique case (cmd_type'(req_tuser))
         CMD_WRITE_BEGIN: begin
            if (slot >= SLOT_COUNT_B) begin
               q_op.status = STAT_BOUND;
            end else if (data_size > SLOT_BYTES_B) begin
               q_op.status = STAT_TOO_LARGE;
            end else begin
               q_op.kind = OP_BEGIN;
               q_op.arg  = data_size;
            end
         end
         CMD_WRITE_DATA: begin
            q_op.kind = OP_DATA;
            q_op.arg  = data_byte;
         end
         CMD_READ: begin
            if (slot >= SLOT_COUNT_B) begin
               q_op.status = STAT_BOUND;
            end else begin
               q_op.kind = OP_READ;
               q_op.arg  = buffer_length;
            end
         end
         default: begin
            q_op.status = STAT_INVALID;
         end
      endcase
   end

endmodule

// File: src/csms_queue.sv
// ----------------------------------------------------------------------------
// csms_queue
// Short operation queue between the front and the back.
// ----------------------------------------------------------------------------
module csms_queue
   import csms_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: src/csms_back.sv
// ----------------------------------------------------------------------------
// csms_back
// Executes operations against the slot table and drives the result register.
// ----------------------------------------------------------------------------
module csms_back
   import csms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  op_type      q_op,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_byte, stored_size, zero pad
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   // slot table
   logic [7:0]        tag_ff   [SLOT_COUNT];
   logic [7:0]        size_ff  [SLOT_COUNT];
   logic [POS_W-1:0]  fill_ff  [SLOT_COUNT];
   logic [15:0]       csum_ff  [SLOT_COUNT];
   logic [7:0]        mem      [MEM_DEPTH];
   logic [7:0]        mem_q_ff;

   // write stream state
   logic [IDX_W-1:0]  wslot_ff, wslot_in;
   logic [POS_W-1:0]  wpos_ff, wpos_in;
   logic [7:0]        wsize_ff, wsize_in;
   logic [15:0]       rsum_ff, rsum_in;

   // read walk state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [SIZE_W-1:0] cur_size_ff, cur_size_in;
   logic [POS_W-1:0]  cur_fill_ff, cur_fill_in;
   logic [POS_W-1:0]  ptr_ff, ptr_in;
   logic [POS_W-1:0]  ptr_nxt;
   logic [15:0]       sum_ff, sum_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [7:0]        rsp_byte_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              emit;
   status_type        emit_status;
   logic [7:0]        emit_byte;
   logic [SIZE_W-1:0] emit_size;
   logic              emit_last;
   logic              begin_we;
   logic              data_we;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ptr_nxt  = ptr_ff + 1'b1;

   // sequencer: next state and outputs
   always_comb begin
      state_in    = state_ff;
      cur_slot_in = cur_slot_ff;
      cur_size_in = cur_size_ff;
      cur_fill_in = cur_fill_ff;
      ptr_in      = ptr_ff;
      sum_in      = sum_ff;
      wslot_in    = wslot_ff;
      wpos_in     = wpos_ff;
      wsize_in    = wsize_ff;
      rsum_in     = rsum_ff;
      q_pop       = 1'b0;
      begin_we    = 1'b0;
      data_we     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = mem_addr(cur_slot_ff, ptr_ff);
      emit        = 1'b0;
      emit_status = STAT_OK;
      emit_byte   = 8'd0;
      emit_size   = '0;
      emit_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_op.kind)
                  OP_ERROR: begin
                     emit        = 1'b1;
                     emit_status = q_op.status;
                  end
                  OP_BEGIN: begin
                     begin_we = 1'b1;
                     wslot_in = q_op.slot;
                     wpos_in  = '0;
                     wsize_in = q_op.arg;
                     rsum_in  = 16'(q_op.slot) + 16'(q_op.arg);
                     emit     = 1'b1;
                  end
                  OP_DATA: begin
                     emit = 1'b1;
                     if ((8'(wpos_ff) < wsize_ff) && (wpos_ff < POS_W'(SLOT_BYTES))) begin
                        data_we = 1'b1;
                        rsum_in = rsum_ff + 16'(q_op.arg);
                        wpos_in = wpos_ff + 1'b1;
                     end else begin
                        emit_status = STAT_TOO_LARGE;
                     end
                  end
                  OP_READ: begin
                     if (tag_ff[q_op.slot] != 8'(q_op.slot)) begin
                        emit        = 1'b1;
                        emit_status = STAT_NOT_FOUND;
                     end else if (size_ff[q_op.slot] > SLOT_BYTES_B) begin
                        emit        = 1'b1;
                        emit_status = STAT_TOO_LARGE;
                     end else if (q_op.arg < size_ff[q_op.slot]) begin
                        emit        = 1'b1;
                        emit_status = STAT_BUF_SMALL;
                     end else begin
                        cur_slot_in = q_op.slot;
                        cur_size_in = SIZE_W'(size_ff[q_op.slot]);
                        cur_fill_in = fill_ff[q_op.slot];
                        sum_in      = 16'(tag_ff[q_op.slot]) + 16'(size_ff[q_op.slot]);
                        ptr_in      = '0;
                        state_in    = S_SUM;
                     end
                  end
                  default: begin
                     emit        = 1'b1;
                     emit_status = STAT_INVALID;
                  end
               endcase
            end
         end
         S_SUM: begin
            // byte at ptr-1 arrives now; unfilled positions count as zero
            if (ptr_ff != '0) begin
               sum_in = sum_ff + ((ptr_ff <= cur_fill_ff) ? 16'(mem_q_ff) : 16'd0);
            end
            if (ptr_ff < POS_W'(SLOT_BYTES)) begin
               rd_en  = 1'b1;
               ptr_in = ptr_nxt;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (out_free) begin
               if (fold_invert(sum_ff) != csum_ff[cur_slot_ff]) begin
                  emit        = 1'b1;
                  emit_status = STAT_INVALID;
                  state_in    = S_IDLE;
               end else if (cur_size_ff == '0) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = mem_addr(cur_slot_ff, '0);
                  ptr_in   = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = (ptr_ff < cur_fill_ff) ? mem_q_ff : 8'd0;
               emit_size = cur_size_ff;
               emit_last = (ptr_nxt == POS_W'(cur_size_ff));
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = mem_addr(cur_slot_ff, ptr_nxt);
                  ptr_in  = ptr_nxt;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wslot_ff     <= '0;
         wpos_ff      <= '0;
         wsize_ff     <= 8'd0;
         rsum_ff      <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wslot_ff     <= wslot_in;
         wpos_ff      <= wpos_in;
         wsize_ff     <= wsize_in;
         rsum_ff      <= rsum_in;
      end
   end

   // walk registers and result payload
   always_ff @(posedge clock) begin
      cur_slot_ff <= cur_slot_in;
      cur_size_ff <= cur_size_in;
      cur_fill_ff <= cur_fill_in;
      ptr_ff      <= ptr_in;
      sum_ff      <= sum_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_byte_ff   <= emit_byte;
         rsp_size_ff   <= emit_size;
         rsp_last_ff   <= emit_last;
      end
   end

   // slot headers: tag, size, fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_ff[i]  <= TAG_EMPTY;
            size_ff[i] <= 8'd0;
            fill_ff[i] <= '0;
         end
      end else if (begin_we) begin
         tag_ff[q_op.slot]  <= 8'(q_op.slot);
         size_ff[q_op.slot] <= q_op.arg;
         fill_ff[q_op.slot] <= '0;
      end else if (data_we) begin
         fill_ff[wslot_ff] <= wpos_in;
      end
   end

   // checksums, valid once the slot is begun
   always_ff @(posedge clock) begin
      if (begin_we) begin
         csum_ff[q_op.slot] <= fold_invert(rsum_in);
      end else if (data_we) begin
         csum_ff[wslot_ff] <= fold_invert(rsum_in);
      end
   end

   // byte memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (data_we) begin
         mem[mem_addr(wslot_ff, wpos_ff)] <= q_op.arg;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_size_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

   // queue is drained only between operations
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("operation popped while a read walk is running");

   // a byte result never runs past the stored size
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |-> (ptr_ff < POS_W'(cur_size_ff)))
      else $error("read stream ran past the stored size");

   // data writes stay within the slot
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      data_we |-> (wpos_ff < POS_W'(SLOT_BYTES)) && (8'(wpos_ff) < wsize_ff))
      else $error("data write beyond the slot size");

   // the fill count of a walked slot never exceeds its size
   a_fill_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (cur_fill_ff <= POS_W'(cur_size_ff)))
      else $error("slot fill count above its size");

endmodule

// File: src/checked_slot_mailbox_store.sv
// ----------------------------------------------------------------------------
// checked_slot_mailbox_store
// Slot table with checksummed mailboxes: writes stream bytes in, reads verify
// the slot and stream its bytes out.
//
//   channel  direction  tdata                              tuser    tlast
//   req_     in         slot, data_size, data_byte, blen   command  -
//   rsp_     out        read_byte, stored_size             status   last
//
// write begin, write byte and error items finish in the back end's idle state.
// a good read walks all slot bytes through the single memory read port to
// recompute the checksum, then one byte out per cycle while the output is free.
// reset clears the slot tags at once; there is no clearing pass.
// a two-item queue lets requests be taken while the back end is busy or the
// result register is stalled.
// ----------------------------------------------------------------------------
module checked_slot_mailbox_store
   import csms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // slot, data_size, data_byte, buffer_length
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_byte, stored_size, zero pad
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   logic   q_full;
   logic   q_push;
   op_type q_push_op;
   logic   q_pop;
   logic   q_valid;
   op_type q_head_op;

   // front: accept and classify
   csms_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_push_op)
   );

   // operation queue
   csms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (q_head_op)
   );

   // back: table, checksum walk and results
   csms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_op       (q_head_op),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
